// ----- rtl/obl_pkg.sv -----
`timescale 1ns / 1ps
package obl_pkg;

  localparam int SIDE_DEPTH_DEF = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_IN_W = 48;
  localparam int QTY_W = 47;
  localparam int ID_W = 64;
  localparam int LIMIT_W = 7;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_UNINIT   = 3'd1,
    ST_STALE    = 3'd2,
    ST_GAP      = 3'd3,
    ST_APPLIED  = 3'd4,
    ST_SKIPPED  = 3'd5,
    ST_FULL     = 3'd6,
    ST_LISTING  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    OP_SNAP  = 3'd0,
    OP_UPD   = 3'd1,
    OP_BID   = 3'd2,
    OP_ASK   = 3'd3,
    OP_LBID  = 3'd4,
    OP_LASK  = 3'd5,
    OP_CLR   = 3'd6,
    OP_NOP   = 3'd7
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [PRICE_W-1:0]   price;
    logic [QTY_W-1:0]     qty;
    logic                 pos;
    logic [ID_W-1:0]      first_id;
    logic [ID_W-1:0]      final_id;
    logic [LIMIT_W-1:0]   limit;
  } entry_t;

  typedef enum logic [2:0] {
    SD_NONE  = 3'd0,
    SD_CLEAR = 3'd1,
    SD_CMP   = 3'd2,
    SD_APPLY = 3'd3,
    SD_ROT   = 3'd4
  } side_op_t;

  typedef struct packed {
    side_op_t             op;
    logic [PRICE_W-1:0]   price;
    logic [QTY_W-1:0]     qty;
    logic                 pos;
  } side_cmd_t;

endpackage

// ----- rtl/order_book_level_table_unit.sv -----
`timescale 1ns / 1ps
// Order book level table: two sorted price-level rows (bids best-high first,
// asks best-low first) with a sequence id and a ready flag. Items enter a
// two-word queue and a back end executes them; every item gives one result
// word except a list that finds levels, which gives one word per listed level
// (tlast on the final one). Headers, clears, skipped levels and empty lists
// finish in the back end's idle state; an applied level passes a compare step
// that matches the key against every cell of the row, then an apply step that
// shifts the row for the insert or delete. A list that returns levels rotates
// the row once through its head cell, which feeds the output, so it
// is back in order when the list ends. Output backpressure stalls the back
// end only; the queue keeps taking input until both of its words are held.
module order_book_level_table_unit #(
  parameter int SIDE_DEPTH = obl_pkg::SIDE_DEPTH_DEF,
  localparam int CW        = $clog2(SIDE_DEPTH + 1),
  localparam int OUT_RAW   = obl_pkg::PRICE_W + obl_pkg::QTY_W + 2 * CW + obl_pkg::ID_W + 1,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8,
  localparam int IN_RAW    = obl_pkg::PRICE_W + obl_pkg::QTY_IN_W + 2 * obl_pkg::ID_W +
                             obl_pkg::LIMIT_W,
  localparam int IN_W      = ((IN_RAW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // level_price_in, level_quantity_in, first id, final id, list_limit
  input  logic [IN_W-1:0]   in_tdata,
  // func
  input  logic [2:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // level_price_out, level_quantity_out, bid_count, ask_count, current_id, ready_flag
  output logic [OUT_W-1:0]  out_tdata,
  // status, level_valid
  output logic [3:0]        out_tuser,
  output logic              out_tlast
);

  localparam int O_QTY = obl_pkg::PRICE_W;
  localparam int O_F1  = O_QTY + obl_pkg::QTY_IN_W;
  localparam int O_F2  = O_F1 + obl_pkg::ID_W;
  localparam int O_LIM = O_F2 + obl_pkg::ID_W;

  obl_pkg::entry_t             q_head;
  logic                        q_valid, q_pop;
  obl_pkg::side_cmd_t          bid_cmd, ask_cmd;
  logic [CW-1:0]               bid_held, ask_held, bid_hn, ask_hn;
  obl_pkg::status_t            bid_st, ask_st, o_st;
  logic [obl_pkg::PRICE_W-1:0] bid_hp, ask_hp, o_price;
  logic [obl_pkg::QTY_W-1:0]   bid_hq, ask_hq, o_qty;
  logic                        o_lv, o_rdy;
  logic [CW-1:0]               o_b, o_a;
  logic [obl_pkg::ID_W-1:0]    o_id;

  obl_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_func  (in_tuser),
    .in_price (in_tdata[O_QTY-1:0]),
    .in_qty   (in_tdata[O_F1-1:O_QTY]),
    .in_first (in_tdata[O_F2-1:O_F1]),
    .in_final (in_tdata[O_LIM-1:O_F2]),
    .in_limit (in_tdata[O_LIM+obl_pkg::LIMIT_W-1:O_LIM]),
    .q_valid, .q_head, .q_pop
  );

  obl_side #(.SIDE_DEPTH(SIDE_DEPTH), .DESCEND(1'b1)) u_bid (
    .clk, .rst_n, .cmd(bid_cmd), .held_o(bid_held), .held_nxt_o(bid_hn),
    .status_o(bid_st), .head_price(bid_hp), .head_qty(bid_hq)
  );

  obl_side #(.SIDE_DEPTH(SIDE_DEPTH), .DESCEND(1'b0)) u_ask (
    .clk, .rst_n, .cmd(ask_cmd), .held_o(ask_held), .held_nxt_o(ask_hn),
    .status_o(ask_st), .head_price(ask_hp), .head_qty(ask_hq)
  );

  obl_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .bid_cmd, .ask_cmd,
    .bid_held, .ask_held, .bid_held_nxt(bid_hn), .ask_held_nxt(ask_hn),
    .bid_status(bid_st), .ask_status(ask_st),
    .bid_head_price(bid_hp), .bid_head_qty(bid_hq),
    .ask_head_price(ask_hp), .ask_head_qty(ask_hq),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(o_st), .out_price(o_price), .out_qty(o_qty), .out_lv(o_lv),
    .out_last(out_tlast), .out_bcnt(o_b), .out_acnt(o_a), .out_id(o_id), .out_rdy(o_rdy)
  );

  // pack result word, zero fill to whole bytes
  assign out_tdata = OUT_W'({o_rdy, o_id, o_a, o_b, o_qty, o_price});
  assign out_tuser = {o_lv, o_st};

endmodule

// ----- rtl/obl_front.sv -----
`timescale 1ns / 1ps
module obl_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2:0]                         in_func,
  input  logic [obl_pkg::PRICE_W-1:0]        in_price,
  input  logic [obl_pkg::QTY_IN_W-1:0]       in_qty,
  input  logic [obl_pkg::ID_W-1:0]           in_first,
  input  logic [obl_pkg::ID_W-1:0]           in_final,
  input  logic [obl_pkg::LIMIT_W-1:0]        in_limit,
  output logic                               q_valid,
  output obl_pkg::entry_t                    q_head,
  input  logic                               q_pop
);

  obl_pkg::entry_t q_r [2];
  obl_pkg::entry_t ent;
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = q_r[rp_r];

  // classify the raw function code
  always_comb begin
    ent.op       = obl_pkg::op_t'(in_func);
    ent.price    = in_price;
    ent.qty      = in_qty[obl_pkg::QTY_W-1:0];
    ent.pos      = !in_qty[obl_pkg::QTY_IN_W-1] && (in_qty != '0);
    ent.first_id = in_first;
    ent.final_id = in_final;
    ent.limit    = in_limit;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/obl_side.sv -----
`timescale 1ns / 1ps
module obl_side #(
  parameter int SIDE_DEPTH = obl_pkg::SIDE_DEPTH_DEF,
  parameter bit DESCEND    = 1'b1,
  localparam int CW        = $clog2(SIDE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  obl_pkg::side_cmd_t            cmd,
  output logic [CW-1:0]                 held_o,
  output logic [CW-1:0]                 held_nxt_o,
  output obl_pkg::status_t              status_o,
  output logic [obl_pkg::PRICE_W-1:0]   head_price,
  output logic [obl_pkg::QTY_W-1:0]     head_qty
);

  logic [obl_pkg::PRICE_W-1:0] pr_r [SIDE_DEPTH];
  logic [obl_pkg::QTY_W-1:0]   qt_r [SIDE_DEPTH];
  logic [SIDE_DEPTH-1:0]       gt_r, eq_r, gt_nxt, eq_nxt;
  logic [obl_pkg::PRICE_W-1:0] key_r;
  logic [obl_pkg::QTY_W-1:0]   kq_r;
  logic                        kpos_r;
  logic [CW-1:0]               held_r, held_nxt;
  logic                        hit, full, do_ovr, do_del, do_ins;

  assign hit    = |eq_r;
  assign full   = (held_r == CW'(SIDE_DEPTH));
  assign do_ovr = hit && kpos_r;
  assign do_del = hit && !kpos_r;
  assign do_ins = !hit && kpos_r && !full;

  assign status_o   = (!hit && kpos_r && full) ? obl_pkg::ST_FULL : obl_pkg::ST_APPLIED;
  assign held_o     = held_r;
  assign held_nxt_o = held_nxt;
  assign head_price = pr_r[0];
  assign head_qty   = qt_r[0];

  // compare every cell against the key at once
  always_comb begin
    for (int j = 0; j < SIDE_DEPTH; j++) begin
      gt_nxt[j] = (CW'(j) < held_r) &&
                  (DESCEND ? (pr_r[j] > cmd.price) : (pr_r[j] < cmd.price));
      eq_nxt[j] = (CW'(j) < held_r) && (pr_r[j] == cmd.price);
    end
  end

  always_comb begin
    held_nxt = held_r;
    case (cmd.op)
      obl_pkg::SD_CLEAR: held_nxt = '0;
      obl_pkg::SD_APPLY: begin
        if (do_del) held_nxt = held_r - CW'(1);
        else if (do_ins) held_nxt = held_r + CW'(1);
      end
      default: held_nxt = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == obl_pkg::SD_CMP) begin
      gt_r   <= gt_nxt;
      eq_r   <= eq_nxt;
      key_r  <= cmd.price;
      kq_r   <= cmd.qty;
      kpos_r <= cmd.pos;
    end
  end

  for (genvar j = 0; j < SIDE_DEPTH; j++) begin : g_cell
    localparam int NX = (j + 1) % SIDE_DEPTH;
    localparam int PV = (j == 0) ? 0 : j - 1;
    always_ff @(posedge clk) begin
      case (cmd.op)
        obl_pkg::SD_APPLY: begin
          if (do_ovr && eq_r[j]) begin
            qt_r[j] <= kq_r;
          end else if (do_del && !gt_r[j] && (j < SIDE_DEPTH - 1)) begin
            pr_r[j] <= pr_r[NX];
            qt_r[j] <= qt_r[NX];
          end else if (do_ins && !gt_r[j]) begin
            if ((j == 0) || gt_r[PV]) begin
              pr_r[j] <= key_r;
              qt_r[j] <= kq_r;
            end else begin
              pr_r[j] <= pr_r[PV];
              qt_r[j] <= qt_r[PV];
            end
          end
        end
        obl_pkg::SD_ROT: begin
          pr_r[j] <= pr_r[NX];
          qt_r[j] <= qt_r[NX];
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/obl_back.sv -----
`timescale 1ns / 1ps
module obl_back #(
  parameter int SIDE_DEPTH = obl_pkg::SIDE_DEPTH_DEF,
  localparam int CW        = $clog2(SIDE_DEPTH + 1),
  localparam int IW        = $clog2(SIDE_DEPTH),
  localparam int MW        = (CW > obl_pkg::LIMIT_W) ? CW : obl_pkg::LIMIT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  obl_pkg::entry_t               q_head,
  output logic                          q_pop,
  output obl_pkg::side_cmd_t            bid_cmd,
  output obl_pkg::side_cmd_t            ask_cmd,
  input  logic [CW-1:0]                 bid_held,
  input  logic [CW-1:0]                 ask_held,
  input  logic [CW-1:0]                 bid_held_nxt,
  input  logic [CW-1:0]                 ask_held_nxt,
  input  obl_pkg::status_t              bid_status,
  input  obl_pkg::status_t              ask_status,
  input  logic [obl_pkg::PRICE_W-1:0]   bid_head_price,
  input  logic [obl_pkg::QTY_W-1:0]     bid_head_qty,
  input  logic [obl_pkg::PRICE_W-1:0]   ask_head_price,
  input  logic [obl_pkg::QTY_W-1:0]     ask_head_qty,
  output logic                          out_valid,
  input  logic                          out_ready,
  output obl_pkg::status_t              out_status,
  output logic [obl_pkg::PRICE_W-1:0]   out_price,
  output logic [obl_pkg::QTY_W-1:0]     out_qty,
  output logic                          out_lv,
  output logic                          out_last,
  output logic [CW-1:0]                 out_bcnt,
  output logic [CW-1:0]                 out_acnt,
  output logic [obl_pkg::ID_W-1:0]      out_id,
  output logic                          out_rdy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_LIST  = 3'b100
  } state_t;

  state_t                      st_r, st_nxt;
  logic [obl_pkg::ID_W-1:0]    seq_r, seq_nxt;
  logic                        book_r, book_nxt, acc_r, acc_nxt;
  logic                        ask_r, ask_nxt;
  logic [CW-1:0]               n_r, n_nxt, k_r, k_nxt, held_sel, lim_n;
  logic [IW-1:0]               rot_r, rot_nxt;
  logic                        out_free;
  logic                        emit, e_lv, e_last;
  obl_pkg::status_t            e_st;
  logic [obl_pkg::PRICE_W-1:0] e_price;
  logic [obl_pkg::QTY_W-1:0]   e_qty;
  logic                        ov_r;
  obl_pkg::status_t            os_r;
  logic [obl_pkg::PRICE_W-1:0] op_r;
  logic [obl_pkg::QTY_W-1:0]   oq_r;
  logic                        olv_r, olast_r, ordy_r;
  logic [CW-1:0]               ob_r, oa_r;
  logic [obl_pkg::ID_W-1:0]    oid_r;
  obl_pkg::side_op_t           sop;

  assign out_free = !ov_r || out_ready;
  assign held_sel = (q_head.op == obl_pkg::OP_LASK) ? ask_held : bid_held;
  assign lim_n    = (MW'(q_head.limit) < MW'(held_sel)) ? CW'(q_head.limit) : held_sel;

  always_comb begin
    st_nxt   = st_r;
    seq_nxt  = seq_r;
    book_nxt = book_r;
    acc_nxt  = acc_r;
    ask_nxt  = ask_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    rot_nxt  = rot_r;
    q_pop    = 1'b0;
    sop      = obl_pkg::SD_NONE;
    bid_cmd  = '{op: obl_pkg::SD_NONE, price: q_head.price, qty: q_head.qty, pos: q_head.pos};
    ask_cmd  = bid_cmd;
    emit     = 1'b0;
    e_st     = obl_pkg::ST_DONE;
    e_price  = '0;
    e_qty    = '0;
    e_lv     = 1'b0;
    e_last   = 1'b1;
    case (st_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_head.op)
            obl_pkg::OP_SNAP: begin
              bid_cmd.op = obl_pkg::SD_CLEAR;
              ask_cmd.op = obl_pkg::SD_CLEAR;
              seq_nxt    = q_head.final_id;
              book_nxt   = 1'b1;
              acc_nxt    = 1'b1;
              emit       = 1'b1;
            end
            obl_pkg::OP_UPD: begin
              emit    = 1'b1;
              acc_nxt = 1'b0;
              if (!book_r) begin
                e_st = obl_pkg::ST_UNINIT;
              end else if (q_head.final_id <= seq_r) begin
                e_st = obl_pkg::ST_STALE;
              end else if ((seq_r != '1) &&
                           (q_head.first_id > seq_r + obl_pkg::ID_W'(1))) begin
                e_st = obl_pkg::ST_GAP;
              end else begin
                seq_nxt = q_head.final_id;
                acc_nxt = 1'b1;
              end
            end
            obl_pkg::OP_BID, obl_pkg::OP_ASK: begin
              if (!acc_r) begin
                emit = 1'b1;
                e_st = obl_pkg::ST_SKIPPED;
              end else begin
                ask_nxt = (q_head.op == obl_pkg::OP_ASK);
                sop     = obl_pkg::SD_CMP;
                st_nxt  = S_APPLY;
              end
            end
            obl_pkg::OP_LBID, obl_pkg::OP_LASK: begin
              if (lim_n == '0) begin
                emit = 1'b1;
                e_st = obl_pkg::ST_LISTING;
              end else begin
                ask_nxt = (q_head.op == obl_pkg::OP_LASK);
                n_nxt   = lim_n;
                k_nxt   = '0;
                rot_nxt = '0;
                st_nxt  = S_LIST;
              end
            end
            obl_pkg::OP_CLR: begin
              bid_cmd.op = obl_pkg::SD_CLEAR;
              ask_cmd.op = obl_pkg::SD_CLEAR;
              seq_nxt    = '0;
              book_nxt   = 1'b0;
              acc_nxt    = 1'b0;
              emit       = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_APPLY: begin
        if (out_free) begin
          sop    = obl_pkg::SD_APPLY;
          emit   = 1'b1;
          e_st   = ask_r ? ask_status : bid_status;
          st_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        // walk the whole row once so it ends in its original order
        if ((k_r >= n_r) || out_free) begin
          sop     = obl_pkg::SD_ROT;
          rot_nxt = rot_r + IW'(1);
          if (rot_r == IW'(SIDE_DEPTH - 1)) st_nxt = S_IDLE;
          if (k_r < n_r) begin
            emit    = 1'b1;
            e_st    = obl_pkg::ST_LISTING;
            e_price = ask_r ? ask_head_price : bid_head_price;
            e_qty   = ask_r ? ask_head_qty : bid_head_qty;
            e_lv    = 1'b1;
            e_last  = (k_r + CW'(1) == n_r);
            k_nxt   = k_r + CW'(1);
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (sop != obl_pkg::SD_NONE) begin
      if (st_r == S_IDLE) begin
        if (ask_nxt) ask_cmd.op = sop;
        else bid_cmd.op = sop;
      end else begin
        if (ask_r) ask_cmd.op = sop;
        else bid_cmd.op = sop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      seq_r  <= '0;
      book_r <= 1'b0;
      acc_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      seq_r  <= seq_nxt;
      book_r <= book_nxt;
      acc_r  <= acc_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ask_r <= ask_nxt;
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    rot_r <= rot_nxt;
    if (emit) begin
      os_r    <= e_st;
      op_r    <= e_price;
      oq_r    <= e_qty;
      olv_r   <= e_lv;
      olast_r <= e_last;
      ob_r    <= bid_held_nxt;
      oa_r    <= ask_held_nxt;
      oid_r   <= seq_nxt;
      ordy_r  <= book_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_price  = op_r;
  assign out_qty    = oq_r;
  assign out_lv     = olv_r;
  assign out_last   = olast_r;
  assign out_bcnt   = ob_r;
  assign out_acnt   = oa_r;
  assign out_id     = oid_r;
  assign out_rdy    = ordy_r;

endmodule

// ----- rtl/obl_check.sv -----
`timescale 1ns / 1ps
module obl_check #(
  parameter int SIDE_DEPTH = obl_pkg::SIDE_DEPTH_DEF,
  localparam int CW        = $clog2(SIDE_DEPTH + 1),
  localparam int OUT_RAW   = obl_pkg::PRICE_W + obl_pkg::QTY_W + 2 * CW + obl_pkg::ID_W + 1,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8,
  localparam int O_ID      = obl_pkg::PRICE_W + obl_pkg::QTY_W + 2 * CW
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [3:0]       out_tuser,
  input logic             out_tlast
);

  localparam int LV_W = obl_pkg::PRICE_W + obl_pkg::QTY_W;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped under backpressure");

  a_lv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata[LV_W-1:0] == '0)
    else $error("level fields set without level_valid");

  a_lv_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == obl_pkg::ST_LISTING)
    else $error("listed level with non-listing status");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tlast)
    else $error("non-level result not last");

  a_id_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[O_ID+obl_pkg::ID_W] |-> out_tdata[O_ID+obl_pkg::ID_W-1:O_ID] == '0)
    else $error("sequence id set while book not ready");

endmodule

bind order_book_level_table_unit obl_check #(.SIDE_DEPTH(SIDE_DEPTH)) u_obl_check (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 64;
  localparam int IN_W  = 216;
  localparam int OUT_W = 160;

  typedef struct {
    obl_pkg::status_t st;
    bit [31:0]    price;
    bit [46:0]    qty;
    bit           valid;
    bit           last;
    bit [6:0]     bids;
    bit [6:0]     asks;
    bit [63:0]    id;
    bit           ready;
  } book_result_t;

  // Book mirror: side 0 holds bids (high first), side 1 holds asks (low first).
  class book_scoreboard;
    bit [31:0]    px [2][DEPTH];
    bit [46:0]    qx [2][DEPTH];
    int           held [2];
    bit [63:0]    seq_id;
    bit           ready;
    bit           accepted;
    book_result_t pending_q [$];
    int           errors;

    function void push(obl_pkg::status_t st, bit [31:0] p, bit [46:0] q, bit v, bit l);
      book_result_t r;
      r.st = st; r.price = p; r.qty = q; r.valid = v; r.last = l;
      r.bids = 7'(held[0]); r.asks = 7'(held[1]); r.id = seq_id; r.ready = ready;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function obl_pkg::status_t apply_level(int s, bit [31:0] price, bit [47:0] q);
      int  i;
      int  n;
      bit  positive;
      n = held[s];
      i = 0;
      positive = !q[47] && q != 0;
      while (i < n && (s == 0 ? px[s][i] > price : px[s][i] < price)) i++;
      if (i < n && px[s][i] == price) begin
        if (positive) begin
          qx[s][i] = q[46:0];
        end else begin
          for (int k = i; k < n - 1; k++) begin
            px[s][k] = px[s][k+1];
            qx[s][k] = qx[s][k+1];
          end
          held[s] = n - 1;
        end
        return obl_pkg::ST_APPLIED;
      end
      if (!positive) return obl_pkg::ST_APPLIED;
      if (n >= DEPTH) return obl_pkg::ST_FULL;
      for (int k = n; k > i; k--) begin
        px[s][k] = px[s][k-1];
        qx[s][k] = qx[s][k-1];
      end
      px[s][i] = price;
      qx[s][i] = q[46:0];
      held[s] = n + 1;
      return obl_pkg::ST_APPLIED;
    endfunction

    // Work out the result words one accepted input word causes.
    function void note_input(obl_pkg::op_t op, bit [31:0] price, bit [47:0] q,
                             bit [63:0] first_id, bit [63:0] final_id, bit [6:0] lim);
      obl_pkg::status_t st;
      int      n;
      int      s;
      st = obl_pkg::ST_DONE;
      case (op)
        obl_pkg::OP_SNAP: begin
          held[0] = 0; held[1] = 0; seq_id = final_id; ready = 1; accepted = 1;
        end
        obl_pkg::OP_UPD: begin
          if (!ready) st = obl_pkg::ST_UNINIT;
          else if (final_id <= seq_id) st = obl_pkg::ST_STALE;
          else if (seq_id != '1 && first_id > seq_id + 64'd1) st = obl_pkg::ST_GAP;
          accepted = (st == obl_pkg::ST_DONE);
          if (accepted) seq_id = final_id;
        end
        obl_pkg::OP_BID: st = accepted ? apply_level(0, price, q) : obl_pkg::ST_SKIPPED;
        obl_pkg::OP_ASK: st = accepted ? apply_level(1, price, q) : obl_pkg::ST_SKIPPED;
        obl_pkg::OP_LBID, obl_pkg::OP_LASK: begin
          s = (op == obl_pkg::OP_LASK) ? 1 : 0;
          n = (int'(lim) < held[s]) ? int'(lim) : held[s];
          if (n == 0) push(obl_pkg::ST_LISTING, 0, 0, 0, 1);
          for (int k = 0; k < n; k++)
            push(obl_pkg::ST_LISTING, px[s][k], qx[s][k], 1, k == n - 1);
          return;
        end
        obl_pkg::OP_CLR: begin
          held[0] = 0; held[1] = 0; seq_id = 0; ready = 0; accepted = 0;
        end
        default: ;
      endcase
      push(st, 0, 0, 0, 1);
    endfunction

    task report(string what, bit [63:0] got, bit [63:0] want);
      $display("mismatch on %s: got %0h, want %0h (t=%0t)", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(book_result_t g);
      book_result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      w = pending_q.pop_front();
      if (g.st != w.st) report("status", g.st, w.st);
      if (g.price != w.price) report("price", g.price, w.price);
      if (g.qty != w.qty) report("quantity", g.qty, w.qty);
      if (g.valid != w.valid) report("level_valid", g.valid, w.valid);
      if (g.last != w.last) report("last", g.last, w.last);
      if (g.bids != w.bids) report("bid_count", g.bids, w.bids);
      if (g.asks != w.asks) report("ask_count", g.asks, w.asks);
      if (g.id != w.id) report("current_id", g.id, w.id);
      if (g.ready != w.ready) report("ready_flag", g.ready, w.ready);
    endtask
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [2:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic [3:0]       out_tuser;
  logic             out_tlast;

  book_scoreboard   sb = new();
  bit               calm = 0;
  int               n_sent = 0;

  order_book_level_table_unit u_top (.*);

  initial forever #6 clk = ~clk;

  // Random output stalls, none while calm.
  always @(posedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 23);

  // Unpack each accepted result word and check it.
  always @(posedge clk) begin
    book_result_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.st = obl_pkg::status_t'(out_tuser[2:0]);
      g.valid = out_tuser[3];
      g.price = out_tdata[31:0];
      g.qty = out_tdata[78:32];
      g.bids = out_tdata[85:79];
      g.asks = out_tdata[92:86];
      g.id = out_tdata[156:93];
      g.ready = out_tdata[157];
      g.last = out_tlast;
      sb.check_result(g);
    end
  end

  // Offer one word; hold it until taken, then note it. Valid stays high so
  // the next word can follow without a bubble.
  task automatic send_word(obl_pkg::op_t op, bit [31:0] price, bit [47:0] q,
                           bit [63:0] first_id, bit [63:0] final_id, bit [6:0] lim);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {1'b0, lim, final_id, first_id, q, price};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, price, q, first_id, final_id, lim);
    n_sent++;
  endtask

  task automatic level(bit is_ask, bit [31:0] price, bit [47:0] q);
    send_word(is_ask ? obl_pkg::OP_ASK : obl_pkg::OP_BID, price, q, 0, 0, 0);
  endtask

  task automatic list_side(bit is_ask, bit [6:0] lim);
    send_word(is_ask ? obl_pkg::OP_LASK : obl_pkg::OP_LBID, 0, 0, 0, 0, lim);
  endtask

  // Header passing every test, or refused one if broken; snapshot near max id.
  task automatic header(bit broken);
    bit [63:0] s;
    s = sb.seq_id;
    if (s > 64'hFFFF_FFFF_FFFF_0000) begin
      send_word(obl_pkg::OP_SNAP, 0, 0, 0, 64'($urandom_range(0, 1000)), 0);
    end else if (!broken) begin
      send_word(obl_pkg::OP_UPD, 0, 0, s + 64'd1 - 64'($urandom_range(0, 1)),
                s + 64'($urandom_range(1, 5)), 0);
    end else if ($urandom_range(0, 1)) begin
      send_word(obl_pkg::OP_UPD, 0, 0, s, s - 64'($urandom_range(0, 3)), 0);
    end else begin
      send_word(obl_pkg::OP_UPD, 0, 0, s + 64'($urandom_range(2, 9)), s + 64'd20, 0);
    end
  endtask

  function automatic bit [47:0] rand_qty(bit del);
    if (del) return $urandom_range(0, 1) ? 48'd0 : {1'b1, 15'($urandom), 32'($urandom)};
    return {1'b0, 15'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom), 32'($urandom)}
           | 48'd1;
  endfunction

  initial begin
    bit [31:0] p;
    int        k;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: refusals before init, snapshot, each header test, extremes.
    send_word(obl_pkg::OP_UPD, 0, 0, 1, 2, 0);
    level(0, 100, 5);
    send_word(obl_pkg::OP_SNAP, 0, 0, 0, 100, 0);
    list_side(0, 10);
    level(0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    level(0, 0, 1);
    level(1, 500, 7);
    level(1, 600, 48'h8000_0000_0000);
    level(1, 500, 0);
    level(1, 700, 3);
    send_word(obl_pkg::OP_UPD, 0, 0, 50, 100, 0);
    level(1, 800, 9);
    send_word(obl_pkg::OP_UPD, 0, 0, 102, 110, 0);
    send_word(obl_pkg::OP_UPD, 0, 0, 101, 110, 0);
    level(0, 0, 48'hFFFF_FFFF_FFFF);
    list_side(0, 0);
    list_side(0, 64);
    list_side(1, 1);
    send_word(obl_pkg::OP_NOP, 32'hFFFF_FFFF, '1, '1, '1, 7'd64);
    send_word(obl_pkg::OP_SNAP, 0, 0, 0, '1, 0);
    send_word(obl_pkg::OP_UPD, 0, 0, 0, '1, 0);
    list_side(1, 64);
    send_word(obl_pkg::OP_CLR, 0, 0, 0, 0, 0);
    list_side(0, 5);

    // Fill the bid side past full with no stalls, then overwrite on a full side.
    calm = 1;
    send_word(obl_pkg::OP_SNAP, 0, 0, 0, 5, 0);
    for (k = 0; k < DEPTH + 2; k++) level(0, 32'(2000 + ((k * 37) % 97)), rand_qty(0));
    level(0, sb.px[0][3], 48'd42);
    list_side(0, 64);
    calm = 0;

    // Hold off until every expected result word has come out.
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);

    while (n_sent < 360) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        if (!sb.ready || $urandom_range(0, 9) == 0)
          send_word(obl_pkg::OP_SNAP, 0, 0, 0, 64'($urandom_range(0, 100000)), 0);
        else header(0);
        repeat ($urandom_range(1, 8)) begin
          p = 1000 + $urandom_range(0, 79);
          level(1'($urandom_range(0, 1)), p, rand_qty($urandom_range(0, 3) == 0));
        end
        if ($urandom_range(0, 2) == 0)
          list_side(1'($urandom_range(0, 1)), 7'($urandom_range(0, 64)));
      end else if (k < 90) begin
        send_word(obl_pkg::op_t'($urandom_range(0, 7)), $urandom,
                  {16'($urandom), 32'($urandom)},
                  {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                  7'($urandom_range(0, 64)));
      end else begin
        header(1);
        repeat ($urandom_range(1, 3)) level(1'($urandom_range(0, 1)), $urandom, rand_qty(0));
      end
    end
    in_tvalid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/obl_pkg.sv
rtl/obl_front.sv
rtl/obl_side.sv
rtl/obl_back.sv
rtl/order_book_level_table_unit.sv
rtl/obl_check.sv
tb/sv/tb.sv
